FILE: rtl/u8d_pkg.sv
// Shared widths, byte-class codes and the byte classifier for the UTF-8 stream decoder.
// No dependencies; imported by the channel interfaces and the core.
package u8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 31;
  localparam int PEND_W = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   cp_t;
  typedef logic [PEND_W-1:0] pend_t;

  // byte class = number of leading ones
  typedef logic [3:0] cls_t;
  localparam cls_t CLS_ASCII = 4'd0;
  localparam cls_t CLS_CONT  = 4'd1;
  localparam cls_t CLS_LEAD2 = 4'd2;
  localparam cls_t CLS_LEAD3 = 4'd3;
  localparam cls_t CLS_LEAD4 = 4'd4;
  localparam cls_t CLS_LEAD5 = 4'd5;
  localparam cls_t CLS_LEAD6 = 4'd6;
  localparam cls_t CLS_FE    = 4'd7;
  localparam cls_t CLS_FF    = 4'd8;

  localparam pend_t PEND_MAX = 3'd5;

  function automatic cls_t byte_class(byte_t b);
    cls_t c;
    priority casez (b)
      8'b0???????: c = CLS_ASCII;
      8'b10??????: c = CLS_CONT;
      8'b110?????: c = CLS_LEAD2;
      8'b1110????: c = CLS_LEAD3;
      8'b11110???: c = CLS_LEAD4;
      8'b111110??: c = CLS_LEAD5;
      8'b1111110?: c = CLS_LEAD6;
      8'b11111110: c = CLS_FE;
      default:     c = CLS_FF;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/u8d_if.sv
// Valid/ready channels of the UTF-8 stream decoder: byte words in, code points out.
// Depends on u8d_pkg.
interface u8d_byte_if;
  import u8d_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
  import u8d_pkg::*;
  logic valid;
  logic ready;
  cp_t  code_point;
  modport source (output valid, output code_point, input ready);
  modport sink   (input valid, input code_point, output ready);
endinterface

FILE: rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder core, one to six byte lead forms.
// The last byte of a sequence passes the input reg and then the result reg before its code
// point is offered; an unaccepted word in the result reg can hold it in the input reg.
// Throughput: one byte word per cycle; a byte with a result stalls only while the
// result reg holds an unaccepted word. The accumulator/pending-count update is
// combinational between the input register and the state registers.
// Reset (synchronous, rst high): both stages empty, accumulator and count zero.
// Depends on u8d_pkg and u8d_if.
module utf8_stream_decoder_core (
  input logic      clk,
  input logic      rst,
  u8d_byte_if.sink bytes,
  u8d_cp_if.source points
);
  import u8d_pkg::*;

  // input stage
  logic  s1_valid;
  byte_t s1_byte;

  // decoder state
  cp_t   acc, acc_next;
  pend_t pend, pend_next;

  // result stage
  logic out_valid;
  cp_t  out_cp;

  cls_t cls;
  logic emit;
  cp_t  emit_cp;
  cp_t  cont_bits;
  logic process;

  always_comb begin
    cls       = byte_class(s1_byte);
    acc_next  = acc;
    pend_next = pend;
    emit      = 1'b0;
    emit_cp   = cp_t'(s1_byte);
    cont_bits = '0;
    unique case (pend)
      3'd1:    cont_bits = cp_t'(s1_byte[5:0]);
      3'd2:    cont_bits = cp_t'({s1_byte[5:0], 6'b0});
      3'd3:    cont_bits = cp_t'({s1_byte[5:0], 12'b0});
      3'd4:    cont_bits = cp_t'({s1_byte[5:0], 18'b0});
      3'd5:    cont_bits = cp_t'({s1_byte[5:0], 24'b0});
      default: cont_bits = '0;
    endcase
    unique case (cls)
      CLS_LEAD2: begin
        acc_next  = cp_t'({s1_byte[4:0], 6'b0});
        pend_next = 3'd1;
      end
      CLS_LEAD3: begin
        acc_next  = cp_t'({s1_byte[3:0], 12'b0});
        pend_next = 3'd2;
      end
      CLS_LEAD4: begin
        acc_next  = cp_t'({s1_byte[2:0], 18'b0});
        pend_next = 3'd3;
      end
      CLS_LEAD5: begin
        acc_next  = cp_t'({s1_byte[1:0], 24'b0});
        pend_next = 3'd4;
      end
      CLS_LEAD6: begin
        acc_next  = cp_t'({s1_byte[0], 30'b0});
        pend_next = 3'd5;
      end
      CLS_CONT: begin
        if (pend != '0 && pend <= PEND_MAX) begin
          acc_next  = acc | cont_bits;
          pend_next = pend - 3'd1;
          emit      = (pend == 3'd1);
          emit_cp   = acc | cont_bits;
        end else begin
          // stray continuation: raw value
          acc_next  = cp_t'(s1_byte);
          pend_next = '0;
          emit      = 1'b1;
        end
      end
      default: begin
        // ASCII, 0xFE, 0xFF: raw value, partial sequence dropped
        acc_next  = cp_t'(s1_byte);
        pend_next = '0;
        emit      = 1'b1;
      end
    endcase
  end

  // a byte with no result never waits on the output side
  assign process     = s1_valid && (!emit || !out_valid || points.ready);
  assign bytes.ready = !s1_valid || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      pend      <= '0;
    end else begin
      if (bytes.ready) begin
        s1_valid <= bytes.valid;
      end
      if (process) begin
        acc  <= acc_next;
        pend <= pend_next;
      end
      if (process && emit) begin
        out_valid <= 1'b1;
      end else if (points.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.in_byte;
    end
    if (process && emit) begin
      out_cp <= emit_cp;
    end
  end

  assign points.valid      = out_valid;
  assign points.code_point = out_cp;

  a_pend_range: assert property (@(posedge clk) disable iff (rst) pend <= PEND_MAX)
    else $error("pending count out of range");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !process) |-> !bytes.ready)
    else $error("input accepted while input stage stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !points.ready) |=> (out_valid && $stable(out_cp)))
    else $error("pending result lost or overwritten");

  a_lead_silent: assert property (@(posedge clk) disable iff (rst)
    (process && cls >= CLS_LEAD2 && cls <= CLS_LEAD6 && !(out_valid && !points.ready))
      |=> !out_valid)
    else $error("lead byte produced a result");

endmodule
